>>> rtl/core/psuh_pkg.sv
// ----------------------------------------------------------------------------
// psuh_pkg
// Shared types and constants of the packed sample unpacker with histograms.
// ----------------------------------------------------------------------------
package psuh_pkg;

  localparam int VAL_W          = 9;
  localparam int OUT_CNT_W      = 32;
  localparam int RES_FIFO_DEPTH = 4;
  localparam int RES_LVL_W      = $clog2(RES_FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_2BIT = 2'd0,
    MODE_4BIT = 2'd1,
    MODE_8BIT = 2'd2
  } bits_mode_e;

  typedef enum logic {
    OP_UNPACK = 1'b0,
    OP_READ   = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_SAMPLE_BITS = 1'b0,
    REG_TWO_POL     = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_a;
    logic signed [VAL_W-1:0] value_b;
    logic signed [VAL_W-1:0] value_c;
    logic signed [VAL_W-1:0] value_d;
    logic [OUT_CNT_W-1:0]    bin_count;
    logic                    last;
  } res_t;

endpackage

>>> rtl/core/psuh_ram.sv
// ----------------------------------------------------------------------------
// psuh_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module psuh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/core/psuh_res_fifo.sv
// ----------------------------------------------------------------------------
// psuh_res_fifo
// Small result queue between the histogram pipeline and the output channel.
// ----------------------------------------------------------------------------
module psuh_res_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  psuh_pkg::res_t             data_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output psuh_pkg::res_t             data_o,
  output logic [psuh_pkg::RES_LVL_W-1:0] level_o
);

  import psuh_pkg::*;

  localparam int PTR_W = $clog2(RES_FIFO_DEPTH);

  res_t               buf_q [RES_FIFO_DEPTH];
  logic [PTR_W-1:0]   wptr_q, rptr_q;
  logic [RES_LVL_W-1:0] cnt_q, cnt_d;
  logic               do_pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rptr_q];
  assign level_o = cnt_q;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/packed_sample_unpack_histogram.sv
// ----------------------------------------------------------------------------
// packed_sample_unpack_histogram
// Unpacks 2/4/8-bit packed words into re-centred groups of four and keeps a
// saturating histogram per polarization in one RAM (read, increment, write).
// ----------------------------------------------------------------------------
// Path: a result passes the stage-1 register and then the result queue after
// its last value issues; a bin read follows the same path after its beat is taken.
// Throughput: one histogram update per cycle while the result queue has room;
// a word holds 16 (2-bit), 8 (4-bit) or 4 (8-bit) values. The RAM port pair
// sets this rate. The next word is taken as the last value issues.
// Reset: registers revert to 8-bit, two polarizations; the histogram RAM is
// then zeroed, all 2*2^clog2(BINS_PER_POLARIZATION) entries, with input stalled.
module packed_sample_unpack_histogram #(
  parameter int BINS_PER_POLARIZATION = 256,
  parameter int COUNT_BITS            = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] packed_word_i,
  input  logic        read_polarization_i,
  input  logic [7:0]  read_bin_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [8:0] value_a_o,
  output logic signed [8:0] value_b_o,
  output logic signed [8:0] value_c_o,
  output logic signed [8:0] value_d_o,
  output logic [31:0] bin_count_o,
  output logic        last_o
);

  import psuh_pkg::*;

  localparam int BIN_W = $clog2(BINS_PER_POLARIZATION);
  localparam int AW    = BIN_W + 1;
  localparam int DEPTH = 2 ** AW;
  localparam logic [8:0]       BINS9   = 9'(BINS_PER_POLARIZATION);
  localparam logic [BIN_W-1:0] TOP_BIN = BIN_W'(BINS_PER_POLARIZATION - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // configuration
  logic [1:0] mode_cfg_q;
  logic       two_pol_q;

  // item register and sequencer
  logic        busy_q;
  logic        op_q;
  logic [31:0] word_q;
  logic        rpol_q;
  logic [7:0]  rbin_q;
  logic [1:0]  mode_q;
  logic        tpol_q;
  logic [3:0]  step_q;
  logic signed [VAL_W-1:0] vals_q [3];

  // clearing
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  // stage 1
  logic          s1_wr_q, s1_rd_q, s1_res_q, s1_rdok_q;
  logic [AW-1:0] s1_addr_q;
  res_t          s1_pay_q;

  // forwarding of the most recent write
  logic                  fwd_valid_q;
  logic [AW-1:0]         fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;

  logic                  accept, drop, fire, step_last, makes_res;
  logic [1:0]            slot;
  logic [7:0]            raw, mask;
  logic signed [VAL_W-1:0] val;
  logic [BIN_W-1:0]      bin;
  logic [AW-1:0]         raddr;
  logic [COUNT_BITS-1:0] rdata, old, incd;
  logic [OUT_CNT_W-1:0]  cnt32;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  res_t                  pay, push_pay, head;
  logic [RES_LVL_W-1:0]  fifo_level;
  logic [RES_LVL_W:0]    credit_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_cfg_q <= MODE_8BIT;
      two_pol_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SAMPLE_BITS: mode_cfg_q <= cfg_data_i;
        REG_TWO_POL:     two_pol_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---- step decode
  assign slot = step_q[1:0];

  always_comb begin
    raw       = '0;
    mask      = 8'hff;
    step_last = 1'b1;
    case (mode_q)
      MODE_2BIT: begin
        raw       = 8'(word_q[{step_q[3:0], 1'b0} +: 2]);
        mask      = 8'h03;
        step_last = (step_q == 4'd15);
      end
      MODE_4BIT: begin
        raw       = 8'(word_q[{step_q[2:0], 2'b00} +: 4]);
        mask      = 8'h0f;
        step_last = (step_q == 4'd7);
      end
      default: begin
        raw       = word_q[{step_q[1:0], 3'b000} +: 8];
        mask      = 8'hff;
        step_last = (step_q == 4'd3);
      end
    endcase
    if (op_q == OP_READ) begin
      step_last = 1'b1;
    end
  end

  assign val = $signed({raw, 1'b0} - {1'b0, mask});
  assign bin = ({1'b0, raw} >= BINS9) ? TOP_BIN : raw[BIN_W-1:0];

  assign makes_res  = (op_q == OP_READ) || (slot == 2'd3);
  assign credit_sum = {1'b0, fifo_level} + (RES_LVL_W+1)'(s1_res_q);
  assign fire       = busy_q && (!makes_res || credit_sum < (RES_LVL_W+1)'(RES_FIFO_DEPTH));

  assign in_stall_o = clr_busy_q || (busy_q && !(fire && step_last));
  assign accept     = in_valid_i && !in_stall_o;
  assign drop       = (opcode_i == OP_UNPACK) && (mode_cfg_q == 2'd3);

  always_comb begin
    if (op_q == OP_READ) begin
      raddr = {rpol_q, rbin_q[BIN_W-1:0]};
    end else begin
      raddr = {tpol_q && slot[1], bin};
    end
  end

  always_comb begin
    pay.value_a   = (op_q == OP_READ) ? '0 : vals_q[0];
    pay.value_b   = (op_q == OP_READ) ? '0 : vals_q[1];
    pay.value_c   = (op_q == OP_READ) ? '0 : vals_q[2];
    pay.value_d   = (op_q == OP_READ) ? '0 : val;
    pay.bin_count = '0;
    pay.last      = step_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      if (accept) begin
        busy_q <= !drop;
        step_q <= '0;
      end else if (fire) begin
        busy_q <= !step_last;
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      word_q <= packed_word_i;
      rpol_q <= read_polarization_i;
      rbin_q <= read_bin_i;
      mode_q <= mode_cfg_q;
      tpol_q <= two_pol_q;
    end
    if (fire && op_q == OP_UNPACK) begin
      case (slot)
        2'd0:    vals_q[0] <= val;
        2'd1:    vals_q[1] <= val;
        2'd2:    vals_q[2] <= val;
        default: ;
      endcase
    end
  end

  // ---- stage 1: read-modify-write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_wr_q  <= 1'b0;
      s1_rd_q  <= 1'b0;
      s1_res_q <= 1'b0;
    end else begin
      s1_wr_q  <= fire && (op_q == OP_UNPACK);
      s1_rd_q  <= fire && (op_q == OP_READ);
      s1_res_q <= fire && makes_res;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= raddr;
    s1_pay_q  <= pay;
    s1_rdok_q <= ({1'b0, rbin_q} < BINS9);
  end

  assign old  = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : rdata;
  assign incd = (old == CNT_MAX) ? old : old + 1'b1;

  always_comb begin
    if (COUNT_BITS > OUT_CNT_W && (old >> OUT_CNT_W) != '0) begin
      cnt32 = '1;
    end else begin
      cnt32 = OUT_CNT_W'(old);
    end
  end

  always_comb begin
    push_pay = s1_pay_q;
    if (s1_rd_q) begin
      push_pay.bin_count = s1_rdok_q ? cnt32 : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (s1_wr_q) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_wr_q) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= incd;
    end
  end

  // ---- clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign ram_we    = clr_busy_q || s1_wr_q;
  assign ram_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_busy_q ? '0 : incd;

  psuh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  psuh_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_res_q),
    .data_i  (push_pay),
    .pop_i   (!out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (head),
    .level_o (fifo_level)
  );

  assign value_a_o   = head.value_a;
  assign value_b_o   = head.value_b;
  assign value_c_o   = head.value_c;
  assign value_d_o   = head.value_d;
  assign bin_count_o = head.bin_count;
  assign last_o      = head.last;

  a_clr_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (in_stall_o && !busy_q))
    else $error("beat taken during histogram clear");

  a_no_fifo_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_res_q |-> (fifo_level < RES_LVL_W'(RES_FIFO_DEPTH) || !out_stall_i))
    else $error("result queue overflow");

  a_no_update_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !(s1_wr_q || s1_rd_q))
    else $error("histogram access during clear");

endmodule

>>> sim/packed_sample_unpack_histogram_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_sample_unpack_histogram_tb
// Drives packed words and bin reads through all sample widths and both
// polarization modes, predicts the unpacked groups and histogram counts, and
// checks every output beat in order under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module packed_sample_unpack_histogram_tb;
  import psuh_pkg::*;

  localparam int          BINS       = 256;
  localparam int          CYCLE_MAX  = 300000;
  localparam int          SETTLE     = 40;
  localparam logic [1:0]  MODE_IDLE  = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [1:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        opcode_i;
  logic [31:0] packed_word_i;
  logic        read_polarization_i;
  logic [7:0]  read_bin_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic signed [8:0] value_a_o;
  logic signed [8:0] value_b_o;
  logic signed [8:0] value_c_o;
  logic signed [8:0] value_d_o;
  logic [31:0] bin_count_o;
  logic        last_o;

  packed_sample_unpack_histogram u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .opcode_i            (opcode_i),
    .packed_word_i       (packed_word_i),
    .read_polarization_i (read_polarization_i),
    .read_bin_i          (read_bin_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .value_a_o           (value_a_o),
    .value_b_o           (value_b_o),
    .value_c_o           (value_c_o),
    .value_d_o           (value_d_o),
    .bin_count_o         (bin_count_o),
    .last_o              (last_o)
  );

  // shadow state
  logic [31:0] hist_count [2*BINS];
  logic [1:0]  bits_mode;
  logic        two_pol;
  res_t        group_q [$];

  int errors;
  int cycles;
  int words_sent;
  int reads_sent;
  int beats_checked;
  int burst_left;
  int hold_ticket;
  int hold_served;
  int hold_left;
  int stall_level;
  int stall_phase;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_served <= 0;
      stall_level <= 0;
      stall_phase <= 0;
    end else begin
      if (hold_served != hold_ticket) begin
        hold_served <= hold_ticket;
        hold_left   <= 300;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 7) < stall_level);
      end
      if (stall_phase == 0) begin
        stall_phase <= $urandom_range(20, 80);
        stall_level <= $urandom_range(0, 5);
      end else begin
        stall_phase <= stall_phase - 1;
      end
    end
  end

  // output checker
  always @(posedge clk_i) begin
    res_t exp_r;
    int   bad;
    bad = 0;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_checked <= beats_checked + 1;
      if (group_q.size() == 0) begin
        $error("unexpected output beat");
        bad++;
      end else begin
        exp_r = group_q.pop_front();
        if (value_a_o !== exp_r.value_a) begin
          $error("value_a: expected %0d, got %0d", exp_r.value_a, value_a_o);
          bad++;
        end
        if (value_b_o !== exp_r.value_b) begin
          $error("value_b: expected %0d, got %0d", exp_r.value_b, value_b_o);
          bad++;
        end
        if (value_c_o !== exp_r.value_c) begin
          $error("value_c: expected %0d, got %0d", exp_r.value_c, value_c_o);
          bad++;
        end
        if (value_d_o !== exp_r.value_d) begin
          $error("value_d: expected %0d, got %0d", exp_r.value_d, value_d_o);
          bad++;
        end
        if (bin_count_o !== exp_r.bin_count) begin
          $error("bin_count: expected %0d, got %0d", exp_r.bin_count, bin_count_o);
          bad++;
        end
        if (last_o !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, last_o);
          bad++;
        end
      end
      errors <= errors + bad;
    end
  end

  task automatic predict_groups(opcode_e op, logic [31:0] word, logic pol, logic [7:0] bin);
    res_t        r;
    int          bits;
    int          groups;
    int          shift;
    int          idx;
    logic [7:0]  fmask;
    logic [7:0]  raw;
    logic [8:0]  v [4];
    r = '0;
    if (op == OP_READ) begin
      r.bin_count = hist_count[{pol, bin}];
      r.last      = 1'b1;
      group_q.push_back(r);
      return;
    end
    case (bits_mode)
      MODE_2BIT: begin bits = 2; groups = 4; end
      MODE_4BIT: begin bits = 4; groups = 2; end
      MODE_8BIT: begin bits = 8; groups = 1; end
      default:   return;
    endcase
    fmask = 8'((1 << bits) - 1);
    shift = 0;
    for (int g = 0; g < groups; g++) begin
      for (int s = 0; s < 4; s++) begin
        raw   = 8'((word >> shift) & fmask);
        v[s]  = 9'({1'b0, raw, 1'b0} - {1'b0, fmask});
        shift += bits;
        idx   = ((two_pol && s >= 2) ? BINS : 0) + raw;
        if (hist_count[idx] != '1) hist_count[idx] = hist_count[idx] + 1;
      end
      r.value_a   = v[0];
      r.value_b   = v[1];
      r.value_c   = v[2];
      r.value_d   = v[3];
      r.bin_count = '0;
      r.last      = (g == groups - 1);
      group_q.push_back(r);
    end
  endtask

  task automatic send_beat(opcode_e op, logic [31:0] word, logic pol, logic [7:0] bin);
    int gap;
    in_valid_i          <= 1'b1;
    opcode_i            <= op;
    packed_word_i       <= word;
    read_polarization_i <= pol;
    read_bin_i          <= bin;
    do @(posedge clk_i); while (in_stall_o);
    predict_groups(op, word, pol, bin);
    if (op == OP_READ) reads_sent++;
    else words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (group_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [1:0] data);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_SAMPLE_BITS) bits_mode = data;
    else two_pol = data[0];
  endtask

  task automatic test_reset_state();
    send_beat(OP_READ, 32'h0, 1'b0, 8'd0);
    send_beat(OP_READ, 32'hFFFF_FFFF, 1'b1, 8'd255);
    send_beat(OP_UNPACK, 32'h0000_0000, 1'b0, 8'd0);
    send_beat(OP_UNPACK, 32'hFFFF_FFFF, 1'b1, 8'hFF);
    send_beat(OP_READ, 32'h0, 1'b0, 8'd255);
    send_beat(OP_READ, 32'h0, 1'b1, 8'd0);
  endtask

  task automatic test_widths();
    write_reg(REG_SAMPLE_BITS, MODE_2BIT);
    send_beat(OP_UNPACK, 32'hE4E4_1B1B, 1'b0, 8'd0);
    send_beat(OP_READ, 32'h0, 1'b0, 8'd3);
    send_beat(OP_READ, 32'h0, 1'b1, 8'd1);
    write_reg(REG_SAMPLE_BITS, MODE_4BIT);
    write_reg(REG_TWO_POL, 2'd0);
    send_beat(OP_UNPACK, 32'hF0A5_0F5A, 1'b0, 8'd0);
    send_beat(OP_UNPACK, 32'hFFFF_FFFF, 1'b0, 8'd0);
    send_beat(OP_READ, 32'h0, 1'b0, 8'd15);
    // right histogram read while everything counts left
    send_beat(OP_READ, 32'h0, 1'b1, 8'd15);
    write_reg(REG_SAMPLE_BITS, MODE_8BIT);
    send_beat(OP_UNPACK, 32'h807F_01FE, 1'b0, 8'd0);
    send_beat(OP_READ, 32'h0, 1'b0, 8'd128);
    // unused width code: word dropped, histogram untouched
    write_reg(REG_SAMPLE_BITS, MODE_IDLE);
    send_beat(OP_UNPACK, 32'hFFFF_FFFF, 1'b0, 8'd0);
    send_beat(OP_READ, 32'h0, 1'b0, 8'd255);
    write_reg(REG_TWO_POL, 2'd3);
    write_reg(REG_SAMPLE_BITS, MODE_2BIT);
    send_beat(OP_UNPACK, 32'h5555_AAAA, 1'b0, 8'd0);
    send_beat(OP_READ, 32'h0, 1'b1, 8'd2);
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [31:0] word;
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_SAMPLE_BITS, (phase == 5) ? MODE_IDLE : 2'($urandom_range(0, 2)));
      write_reg(REG_TWO_POL, 2'($urandom_range(0, 3)));
      for (int n = 0; n < 12; n++) begin
        case ($urandom_range(0, 9))
          0:       word = '1;
          1:       word = '0;
          default: word = $urandom;
        endcase
        if ($urandom_range(0, 4) == 0)
          send_beat(OP_READ, word, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        else
          send_beat(OP_UNPACK, word, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
    write_reg(REG_SAMPLE_BITS, MODE_2BIT);
  endtask

  task automatic test_backpressure();
    hold_ticket++;
    for (int n = 0; n < 24; n++) send_beat(OP_UNPACK, $urandom, 1'b0, 8'd0);
    drain_results();
    for (int b = 0; b < 4; b++) send_beat(OP_READ, 32'h0, 1'(b[0]), 8'(b));
  endtask

  initial begin
    errors        = 0;
    cycles        = 0;
    words_sent    = 0;
    reads_sent    = 0;
    beats_checked = 0;
    burst_left    = 4;
    hold_ticket   = 0;
    bits_mode     = MODE_8BIT;
    two_pol       = 1'b1;
    foreach (hist_count[i]) hist_count[i] = '0;
    rst_ni              = 1'b0;
    cfg_valid_i         = 1'b0;
    cfg_index_i         = REG_SAMPLE_BITS;
    cfg_data_i          = '0;
    in_valid_i          = 1'b0;
    opcode_i            = OP_UNPACK;
    packed_word_i       = '0;
    read_polarization_i = 1'b0;
    read_bin_i          = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_widths();
    test_random_traffic();
    test_backpressure();
    drain_results();

    $display("Covered %0d packed words and %0d bin reads, %0d output beats checked,",
             words_sent, reads_sent, beats_checked);
    $display("over all sample widths, both polarization modes and a long output hold-off.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
